FILE: rtl/owab_pkg.sv
package owab_pkg;

    // pixel and field widths
    localparam int PIXEL_W      = 32;
    localparam int DEST_W       = 24;
    localparam int COORD_W      = 13;
    localparam int WIN_WIDTH_W  = 10;
    localparam int WIN_HEIGHT_W = 8;

    // configuration port
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 13;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_X         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_Y         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAY_ON    = 3'd7;

    // alpha codes
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [PIXEL_W-1:0]     pixel_t;
    typedef logic [DEST_W-1:0]      dest_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

endpackage

FILE: rtl/owab_if.sv
interface owab_in_if;
    logic             valid;
    logic             ready;
    owab_pkg::pixel_t overlay_pixel;
    owab_pkg::pixel_t background_pixel;

    modport source (output valid, output overlay_pixel, output background_pixel,
                    input ready);
    modport sink (input valid, input overlay_pixel, input background_pixel,
                  output ready);
endinterface

interface owab_out_if;
    logic             valid;
    logic             ready;
    logic             write_enable;
    owab_pkg::dest_t  dest_index;
    owab_pkg::pixel_t result_pixel;
    logic             window_valid;
    logic             last_of_window;

    modport source (output valid, output write_enable, output dest_index,
                    output result_pixel, output window_valid, output last_of_window,
                    input ready);
    modport sink (input valid, input write_enable, input dest_index,
                  input result_pixel, input window_valid, input last_of_window,
                  output ready);
endinterface

interface owab_cfg_if;
    logic                 valid;
    logic                 ready;
    owab_pkg::cfg_index_t index;
    owab_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/overlay_window_alpha_blender.sv
// an accepted pixel word goes through the input register, then the result register
// throughput: one pixel word per cycle while result.ready is high, via the register pair
// the configuration port takes a write in every cycle
// reset: config registers, window counters and valid flags clear to zero;
// pixel payload registers are not reset
module overlay_window_alpha_blender #(
    parameter int MAX_W = 512,
    parameter int MAX_H = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    owab_cfg_if.sink       cfg,
    owab_in_if.sink        pixel,
    owab_out_if.source     result
);

    // counter widths follow the largest window
    localparam int CW = (MAX_W > 1) ? $clog2(MAX_W) : 1;
    localparam int RW = (MAX_H > 1) ? $clog2(MAX_H) : 1;
    localparam int CW_EXT = owab_pkg::COORD_W;

    // per-lane blend: (ov*a + bg*(255-a)) >> 8
    function automatic logic [7:0] blend_lane(
        input logic [7:0] ov,
        input logic [7:0] bg,
        input logic [7:0] a
    );
        logic [15:0] sum;
        begin
            sum = 16'(ov) * 16'(a) + 16'(bg) * 16'(8'hFF - a);
            return sum[15:8];
        end
    endfunction

    // configuration registers
    logic signed [owab_pkg::COORD_W-1:0]  win_x_reg;
    logic signed [owab_pkg::COORD_W-1:0]  win_y_reg;
    logic [owab_pkg::WIN_WIDTH_W-1:0]     win_width_reg;
    logic [owab_pkg::WIN_HEIGHT_W-1:0]    win_height_reg;
    logic [owab_pkg::COORD_W-1:0]         screen_width_reg;
    logic [owab_pkg::COORD_W-1:0]         screen_height_reg;
    logic [owab_pkg::COORD_W-1:0]         row_pitch_reg;
    logic                                 overlay_on_reg;

    // window scan counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // input register stage
    logic             s1_valid_reg;
    owab_pkg::pixel_t s1_ov_reg;
    owab_pkg::pixel_t s1_bg_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_last_reg;

    // result register stage
    logic             out_valid_reg;
    logic             out_we_reg,    out_we_next;
    owab_pkg::dest_t  out_dest_reg,  out_dest_next;
    owab_pkg::pixel_t out_pix_reg,   out_pix_next;
    logic             out_wv_reg,    out_wv_next;
    logic             out_last_reg;

    // flow control
    logic out_free;
    logic s1_free;
    logic in_fire;
    logic s1_move;

    // window checks
    logic dims_ok;
    logic last_col;
    logic last_row;
    logic win_valid;

    // address path
    logic [CW_EXT-1:0]     row_pos;
    logic [CW_EXT-1:0]     col_pos;
    logic [2*CW_EXT-1:0]   row_base;
    logic [7:0]            alpha;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_fire  = pixel.valid && s1_free;
    assign s1_move  = s1_valid_reg && out_free;

    assign pixel.ready = s1_free;
    assign cfg.ready   = 1'b1;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg         <= '0;
            win_y_reg         <= '0;
            win_width_reg     <= '0;
            win_height_reg    <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            row_pitch_reg     <= '0;
            overlay_on_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                owab_pkg::REG_WIN_X:         win_x_reg         <= cfg.data;
                owab_pkg::REG_WIN_Y:         win_y_reg         <= cfg.data;
                owab_pkg::REG_WIN_WIDTH:
                    win_width_reg <= cfg.data[owab_pkg::WIN_WIDTH_W-1:0];
                owab_pkg::REG_WIN_HEIGHT:
                    win_height_reg <= cfg.data[owab_pkg::WIN_HEIGHT_W-1:0];
                owab_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data;
                owab_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data;
                owab_pkg::REG_ROW_PITCH:     row_pitch_reg     <= cfg.data;
                owab_pkg::REG_OVERLAY_ON:    overlay_on_reg    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // scan counters: step on every accepted word while the window size
    // is legal; a counter at or past the final place counts as there
    // ---------------------------------------------------------------
    assign dims_ok = (win_width_reg != '0) && (32'(win_width_reg) <= MAX_W) &&
                     (win_height_reg != '0) && (32'(win_height_reg) <= MAX_H);
    assign last_col = dims_ok && (32'(col_reg) >= 32'(win_width_reg) - 32'd1);
    assign last_row = dims_ok && (32'(row_reg) >= 32'(win_height_reg) - 32'd1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (!dims_ok)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // input register: pixel word plus its place in the window
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ov_reg   <= pixel.overlay_pixel;
            s1_bg_reg   <= pixel.background_pixel;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= last_col && last_row;
        end
    end

    // ---------------------------------------------------------------
    // blend and address: window must be on, legal and fully on screen
    // ---------------------------------------------------------------
    assign win_valid = overlay_on_reg && dims_ok &&
                       !win_x_reg[CW_EXT-1] && !win_y_reg[CW_EXT-1] &&
                       ((14'(win_x_reg[CW_EXT-2:0]) + 14'(win_width_reg)) <=
                        14'(screen_width_reg)) &&
                       ((14'(win_y_reg[CW_EXT-2:0]) + 14'(win_height_reg)) <=
                        14'(screen_height_reg));

    assign row_pos  = CW_EXT'(win_y_reg[CW_EXT-2:0]) + CW_EXT'(s1_row_reg);
    assign col_pos  = CW_EXT'(win_x_reg[CW_EXT-2:0]) + CW_EXT'(s1_col_reg);
    assign row_base = (2*CW_EXT)'(row_pos) * (2*CW_EXT)'(row_pitch_reg);
    assign alpha    = s1_ov_reg[31:24];

    always_comb
    begin
        out_we_next   = 1'b0;
        out_dest_next = '0;
        out_pix_next  = '0;
        out_wv_next   = win_valid;
        if (win_valid)
        begin
            out_dest_next = row_base[owab_pkg::DEST_W-1:0] +
                            owab_pkg::DEST_W'(col_pos);
            if (alpha == owab_pkg::ALPHA_OPAQUE)
            begin
                out_we_next  = 1'b1;
                out_pix_next = s1_ov_reg;
            end
            else if (alpha != owab_pkg::ALPHA_CLEAR)
            begin
                // partial alpha: mix color lanes, result is opaque
                out_we_next  = 1'b1;
                out_pix_next = {owab_pkg::ALPHA_OPAQUE,
                                blend_lane(s1_ov_reg[23:16], s1_bg_reg[23:16], alpha),
                                blend_lane(s1_ov_reg[15:8],  s1_bg_reg[15:8],  alpha),
                                blend_lane(s1_ov_reg[7:0],   s1_bg_reg[7:0],   alpha)};
            end
        end
    end

    // ---------------------------------------------------------------
    // result register: holds a word until the sink takes it
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_we_reg   <= out_we_next;
            out_dest_reg <= out_dest_next;
            out_pix_reg  <= out_pix_next;
            out_wv_reg   <= out_wv_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.write_enable   = out_we_reg;
    assign result.dest_index     = out_dest_reg;
    assign result.result_pixel   = out_pix_reg;
    assign result.window_valid   = out_wv_reg;
    assign result.last_of_window = out_last_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 128;
    localparam int ITEMS      = 1150;
    localparam int CALM_ITEMS = 150;   // final stretch with no idling on either side
    localparam int IDLE_LIMIT = 400;   // cycles with no word moving on any port
    localparam int N_DIRECTED = 12;

    // window settings the stimulus walks through, special cases by name
    typedef enum int {
        WIN_OK,
        WIN_CORNER,
        WIN_OFF,
        WIN_NEG_X,
        WIN_NEG_Y,
        WIN_ZERO_W,
        WIN_ZERO_H,
        WIN_WIDE,
        WIN_TALL,
        WIN_PAST_RIGHT,
        WIN_PAST_BOTTOM,
        WIN_WRAP
    } win_case_t;

    typedef struct {
        int x;
        int y;
        int wd;
        int ht;
        int scr_w;
        int scr_h;
        int pitch;
        bit on;
    } win_cfg_t;

    // one result word as the block gives it
    typedef struct packed {
        logic             we;
        owab_pkg::dest_t  dest;
        owab_pkg::pixel_t pix;
        logic             wv;
        logic             last;
    } blend_result_t;

    // directed stimulus row; typed rows carry their result written out
    typedef struct {
        bit               phase;   // 0: straight after reset, 1: directed window
        owab_pkg::pixel_t ov;
        owab_pkg::pixel_t bg;
        bit               typed;
        blend_result_t    want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    owab_cfg_if cfg_if ();
    owab_in_if  pix_if ();
    owab_out_if res_if ();

    overlay_window_alpha_blender #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .pixel  (pix_if),
        .result (res_if)
    );

    always #4 clk = ~clk;

    // directed table: after reset nothing is legal, so every field reads zero;
    // then a 3x2 window that fits the screen exactly, walked once and wrapped
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0},
        '{1'b0, 32'h00000000, 32'h00000000, 1'b1, '0},
        '{1'b0, 32'h80A5A5A5, 32'h5A5A5A5A, 1'b1, '0},
        '{1'b1, 32'h00FFFFFF, 32'h12345678, 1'b0, '0},   // clear alpha, no write
        '{1'b1, 32'hFF123456, 32'hFFFFFFFF, 1'b0, '0},   // opaque copy
        '{1'b1, 32'h01FFFFFF, 32'h00000000, 1'b0, '0},   // faintest blend
        '{1'b1, 32'hFEFFFFFF, 32'hFFFFFFFF, 1'b0, '0},   // strongest blend
        '{1'b1, 32'h80FF00FF, 32'h0000FF00, 1'b0, '0},
        '{1'b1, 32'hFF000000, 32'h00FFFFFF, 1'b0, '0},   // final pixel of window
        '{1'b1, 32'h7F00FF00, 32'hFF00FF00, 1'b0, '0},   // counters back at origin
        '{1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b0, '0},
        '{1'b1, 32'h40ABCDEF, 32'hFEDCBA98, 1'b0, '0}
    };

    // predictor copy of the registers and window counters
    logic signed [owab_pkg::COORD_W-1:0] win_x;
    logic signed [owab_pkg::COORD_W-1:0] win_y;
    logic [owab_pkg::WIN_WIDTH_W-1:0]    win_w;
    logic [owab_pkg::WIN_HEIGHT_W-1:0]   win_h;
    logic [owab_pkg::COORD_W-1:0]        scr_w;
    logic [owab_pkg::COORD_W-1:0]        scr_h;
    logic [owab_pkg::COORD_W-1:0]        pitch;
    logic                                ovl_on;
    logic [6:0]                          row_cnt;
    logic [8:0]                          col_cnt;

    blend_result_t expected_q [$];

    int  fail_count = 0;
    int  n_items    = 0;
    int  n_windows  = 0;
    int  n_cfg      = 0;
    int  n_writes   = 0;
    int  n_ends     = 0;
    int  n_off      = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;

    // register write as the block sees it: field bits only, rest ignored
    function automatic void store_reg(owab_pkg::cfg_index_t idx, owab_pkg::cfg_data_t val);
        case (idx)
            owab_pkg::REG_WIN_X:         win_x  = val;
            owab_pkg::REG_WIN_Y:         win_y  = val;
            owab_pkg::REG_WIN_WIDTH:     win_w  = val[owab_pkg::WIN_WIDTH_W-1:0];
            owab_pkg::REG_WIN_HEIGHT:    win_h  = val[owab_pkg::WIN_HEIGHT_W-1:0];
            owab_pkg::REG_SCREEN_WIDTH:  scr_w  = val;
            owab_pkg::REG_SCREEN_HEIGHT: scr_h  = val;
            owab_pkg::REG_ROW_PITCH:     pitch  = val;
            owab_pkg::REG_OVERLAY_ON:    ovl_on = val[0];
            default: ;
        endcase
    endfunction

    // expected word for one pixel pair, then step the window counters
    function automatic blend_result_t blend_pixel(owab_pkg::pixel_t ov, owab_pkg::pixel_t bg);
        blend_result_t r;
        logic [7:0]    a;
        logic [63:0]   inv;
        logic [63:0]   rb;
        logic [63:0]   g;
        int            xi;
        int            yi;
        bit            dims_ok;
        bit            win_ok;
        bit            last_col;
        bit            last_row;
        r  = '0;
        a  = ov[31:24];
        xi = int'(win_x);
        yi = int'(win_y);
        dims_ok = win_w >= 1 && win_h >= 1 && win_w <= MAX_W && win_h <= MAX_H;
        win_ok  = ovl_on && dims_ok && xi >= 0 && yi >= 0 &&
                  xi + int'(win_w) <= int'(scr_w) && yi + int'(win_h) <= int'(scr_h);
        // a counter left past a shrunken window counts as sitting on the edge
        last_col = dims_ok && int'(col_cnt) >= int'(win_w) - 1;
        last_row = dims_ok && int'(row_cnt) >= int'(win_h) - 1;
        if (win_ok)
        begin
            // address wraps at 24 bits
            r.dest = owab_pkg::dest_t'(longint'(yi + int'(row_cnt)) * longint'(pitch) +
                                       longint'(xi + int'(col_cnt)));
            if (a == owab_pkg::ALPHA_OPAQUE)
            begin
                r.we  = 1'b1;
                r.pix = ov;
            end
            else if (a != owab_pkg::ALPHA_CLEAR)
            begin
                // red/blue and green lanes weighted separately, shift by 8
                inv = 64'(8'hFF - a);
                rb  = (((64'(ov) & 64'h00FF00FF) * 64'(a) +
                        (64'(bg) & 64'h00FF00FF) * inv) >> 8) & 64'h00FF00FF;
                g   = (((64'(ov) & 64'h0000FF00) * 64'(a) +
                        (64'(bg) & 64'h0000FF00) * inv) >> 8) & 64'h0000FF00;
                r.we  = 1'b1;
                r.pix = {owab_pkg::ALPHA_OPAQUE, 24'h0} |
                        owab_pkg::pixel_t'(rb) | owab_pkg::pixel_t'(g);
            end
        end
        r.wv   = win_ok;
        r.last = last_col && last_row;
        // counters run on legal dimensions even when the window is off screen
        if (!dims_ok)
        begin
            row_cnt = '0;
            col_cnt = '0;
        end
        else if (last_col)
        begin
            col_cnt = '0;
            row_cnt = last_row ? 7'd0 : row_cnt + 7'd1;
        end
        else
        begin
            col_cnt = col_cnt + 9'd1;
        end
        return r;
    endfunction

    // a window setting for one phase; legal and on screen unless the case breaks it
    function automatic win_cfg_t pick_window(win_case_t kind);
        win_cfg_t c;
        if ($urandom_range(0, 7) == 0)
        begin
            c.wd = $urandom_range(1, MAX_W);
            c.ht = $urandom_range(1, MAX_H);
        end
        else
        begin
            c.wd = $urandom_range(1, 8);
            c.ht = $urandom_range(1, 4);
        end
        c.x     = $urandom_range(0, 200);
        c.y     = $urandom_range(0, 100);
        c.scr_w = c.x + c.wd + $urandom_range(0, 3);
        c.scr_h = c.y + c.ht + $urandom_range(0, 3);
        c.pitch = c.scr_w + $urandom_range(0, 16);
        c.on    = 1'b1;
        case (kind)
            WIN_CORNER:
            begin
                // largest window flush against the bottom right of a full screen
                c.wd = MAX_W;
                c.ht = MAX_H;
                c.scr_w = 4096;
                c.scr_h = 4096;
                c.x = c.scr_w - MAX_W;
                c.y = c.scr_h - MAX_H;
                c.pitch = 4096;
            end
            WIN_OFF:
            begin
                c.on = 1'b0;
                if ($urandom_range(0, 1))
                begin
                    c.scr_w = 0;
                    c.scr_h = 0;
                    c.pitch = 0;
                end
            end
            WIN_NEG_X:       c.x  = $urandom_range(0, 1) ? -4096 : -int'($urandom_range(1, 4095));
            WIN_NEG_Y:       c.y  = $urandom_range(0, 1) ? -4096 : -int'($urandom_range(1, 4095));
            WIN_ZERO_W:      c.wd = 0;
            WIN_ZERO_H:      c.ht = 0;
            WIN_WIDE:        c.wd = $urandom_range(0, 1) ? 1023 : $urandom_range(MAX_W + 1, 1022);
            WIN_TALL:        c.ht = $urandom_range(0, 1) ? 255 : $urandom_range(MAX_H + 1, 254);
            WIN_PAST_RIGHT:  c.scr_w = c.x + c.wd - 1;
            WIN_PAST_BOTTOM: c.scr_h = c.y + c.ht - 1;
            WIN_WRAP:
            begin
                // far corner of an oversized screen so the address can pass 2^24
                c.wd = $urandom_range(1, 8);
                c.ht = $urandom_range(1, 4);
                c.x = $urandom_range(0, 1) ? 4095 : $urandom_range(3000, 4094);
                c.y = $urandom_range(4000, 4095);
                c.scr_w = 8191;
                c.scr_h = 8191;
                c.pitch = $urandom_range(4097, 8191);
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(owab_pkg::cfg_index_t idx, owab_pkg::cfg_data_t val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        store_reg(idx, val);
        n_cfg++;
    endtask

    // all eight registers; unused upper data bits sometimes carry junk
    task automatic load_window(win_cfg_t c);
        owab_pkg::cfg_data_t junk;
        junk = ($urandom_range(0, 2) == 0) ? owab_pkg::cfg_data_t'($urandom) : '0;
        write_reg(owab_pkg::REG_WIN_X,         owab_pkg::cfg_data_t'(c.x));
        write_reg(owab_pkg::REG_WIN_Y,         owab_pkg::cfg_data_t'(c.y));
        write_reg(owab_pkg::REG_WIN_WIDTH,     {junk[12:10], c.wd[9:0]});
        write_reg(owab_pkg::REG_WIN_HEIGHT,    {junk[12:8], c.ht[7:0]});
        write_reg(owab_pkg::REG_SCREEN_WIDTH,  owab_pkg::cfg_data_t'(c.scr_w));
        write_reg(owab_pkg::REG_SCREEN_HEIGHT, owab_pkg::cfg_data_t'(c.scr_h));
        write_reg(owab_pkg::REG_ROW_PITCH,     owab_pkg::cfg_data_t'(c.pitch));
        write_reg(owab_pkg::REG_OVERLAY_ON,    {junk[12:1], c.on});
        cfg_if.valid <= 1'b0;
        n_windows++;
    endtask

    // let every word in flight come back before touching the registers
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_pixel(owab_pkg::pixel_t ov, owab_pkg::pixel_t bg, bit typed,
                              blend_result_t want);
        blend_result_t pred;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        pix_if.valid            <= 1'b1;
        pix_if.overlay_pixel    <= ov;
        pix_if.background_pixel <= bg;
        do @(posedge clk); while (!pix_if.ready);
        pred = blend_pixel(ov, bg);
        expected_q.push_back(typed ? want : pred);
        n_items++;
        calm = n_items >= ITEMS - CALM_ITEMS;
    endtask

    // alpha leans on clear, opaque and the blend edges
    function automatic owab_pkg::pixel_t rand_overlay();
        logic [7:0] a;
        case ($urandom_range(0, 5))
            0:       a = owab_pkg::ALPHA_CLEAR;
            1:       a = owab_pkg::ALPHA_OPAQUE;
            2:       a = 8'h01;
            3:       a = 8'hFE;
            default: a = 8'($urandom);
        endcase
        return {a, 24'($urandom)};
    endfunction

    // one phase: settle, load a setting, stream pixels that often end mid-window
    task automatic run_window(win_case_t kind);
        win_cfg_t c;
        int       area;
        int       count;
        c = pick_window(kind);
        settle();
        load_window(c);
        if (kind == WIN_OK)
        begin
            area  = c.wd * c.ht;
            count = area * $urandom_range(1, 2) + $urandom_range(0, area);
            if (count > 80) count = 80;
        end
        else
        begin
            count = $urandom_range(8, 40);
        end
        repeat (count) send_pixel(rand_overlay(), $urandom, 1'b0, '0);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // result side: stalls in bursts, none in the final stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left   <= 0;
            res_if.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            stall_left   <= $urandom_range(0, 8);
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        blend_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: result word with none expected, actual we=%b dest=%h pix=%h",
                         $time, res_if.write_enable, res_if.dest_index, res_if.result_pixel);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("write_enable",   32'(want.we),   32'(res_if.write_enable));
                check_field("dest_index",     32'(want.dest), 32'(res_if.dest_index));
                check_field("result_pixel",   want.pix,       res_if.result_pixel);
                check_field("window_valid",   32'(want.wv),   32'(res_if.window_valid));
                check_field("last_of_window", 32'(want.last), 32'(res_if.last_of_window));
                n_writes += int'(want.we);
                n_ends   += int'(want.last);
                n_off    += int'(!want.wv);
            end
        end
    end

    // watchdog on cycles where no word moves on any port
    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding",
                     $time, idle_cycles, expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        win_cfg_t dir_win;
        bit       cur_phase;
        rst_n                   = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = owab_pkg::REG_WIN_X;
        cfg_if.data             = '0;
        pix_if.valid            = 1'b0;
        pix_if.overlay_pixel    = '0;
        pix_if.background_pixel = '0;
        // predictor starts from the reset state
        win_x = '0; win_y = '0; win_w = '0; win_h = '0;
        scr_w = '0; scr_h = '0; pitch = '0; ovl_on = 1'b0;
        row_cnt = '0; col_cnt = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: reset rows, then the small exact-fit window
        dir_win   = '{x: 2, y: 1, wd: 3, ht: 2, scr_w: 5, scr_h: 3, pitch: 8, on: 1'b1};
        cur_phase = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].phase != cur_phase)
            begin
                settle();
                load_window(dir_win);
                cur_phase = directed_rows[i].phase;
            end
            send_pixel(directed_rows[i].ov, directed_rows[i].bg,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        // every special setting once, in order
        for (int k = 0; k <= int'(WIN_WRAP); k++)
            run_window(win_case_t'(k));

        // random settings, mostly legal windows
        while (n_items < ITEMS)
        begin
            if ($urandom_range(0, 9) < 6)
                run_window(WIN_OK);
            else
                run_window(win_case_t'($urandom_range(1, int'(WIN_WRAP))));
        end

        pix_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d pixel words over %0d window settings (%0d register writes)",
                 n_items, n_windows, n_cfg);
        $display("%0d framebuffer writes, %0d window ends, %0d words outside a live window",
                 n_writes, n_ends, n_off);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
